/* sv/bnc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bracket nesting checker package
// Shared types, result codes and character decode helpers.
// ----------------------------------------------------------------------------
package bnc_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 128;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned ERR_W   = 15;
  localparam int unsigned SCORE_W = 64;

  // Result codes carried on the output tuser
  typedef enum logic [1:0] {
    LS_BALANCED   = 2'd0,
    LS_CORRUPTED  = 2'd1,
    LS_INCOMPLETE = 2'd2,
    LS_OVERFLOW   = 2'd3
  } line_status_e;

  // Shift command shared by every cell of the stack chain
  typedef struct packed {
    logic push;
    logic pop;
  } shift_t;

  typedef struct packed {
    logic              hit;
    logic [KIND_W-1:0] kind;
  } kind_t;

  function automatic kind_t opener_kind(input logic [CHAR_W-1:0] c);
    kind_t r;
    r.hit  = 1'b1;
    r.kind = 2'd0;
    case (c)
      8'h28:   r.kind = 2'd0; // (
      8'h5B:   r.kind = 2'd1; // [
      8'h7B:   r.kind = 2'd2; // {
      8'h3C:   r.kind = 2'd3; // <
      default: r.hit  = 1'b0;
    endcase
    return r;
  endfunction

  function automatic kind_t closer_kind(input logic [CHAR_W-1:0] c);
    kind_t r;
    r.hit  = 1'b1;
    r.kind = 2'd0;
    case (c)
      8'h29:   r.kind = 2'd0; // )
      8'h5D:   r.kind = 2'd1; // ]
      8'h7D:   r.kind = 2'd2; // }
      8'h3E:   r.kind = 2'd3; // >
      default: r.hit  = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [ERR_W-1:0] error_points(input logic [CHAR_W-1:0] c);
    logic [ERR_W-1:0] r;
    case (c)
      8'h29:   r = 15'd3;
      8'h5D:   r = 15'd57;
      8'h7D:   r = 15'd1197;
      8'h3E:   r = 15'd25137;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* sv/bnc_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack cell
// One entry of the shifting stack: takes the entry above on push and the
// entry below on pop.
// ----------------------------------------------------------------------------
module bnc_cell import bnc_pkg::*; (
  input  logic              clk_i,
  input  shift_t            shift_i,
  input  logic [KIND_W-1:0] above_i,
  input  logic [KIND_W-1:0] below_i,
  output logic [KIND_W-1:0] kind_o
);

  logic [KIND_W-1:0] kind_d, kind_q;

  always_comb begin
    kind_d = kind_q;
    if (shift_i.push) begin
      kind_d = above_i;
    end else if (shift_i.pop) begin
      kind_d = below_i;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
  end

  assign kind_o = kind_q;

endmodule

/* sv/bnc_fold.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Completion score accumulator
// Folds one popped kind per step: acc = acc * 5 + (kind + 1), modulo 2^64.
// ----------------------------------------------------------------------------
module bnc_fold import bnc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               clr_i,
  input  logic               step_i,
  input  logic [KIND_W-1:0]  kind_i,
  output logic [SCORE_W-1:0] acc_o
);

  logic [SCORE_W-1:0] acc_d, acc_q;
  logic [SCORE_W-1:0] digit;

  assign digit = {{(SCORE_W-KIND_W-1){1'b0}}, {1'b0, kind_i} + 3'd1};

  always_comb begin
    acc_d = acc_q;
    if (clr_i) begin
      acc_d = '0;
    end else if (step_i) begin
      acc_d = (acc_q << 2) + acc_q + digit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

/* sv/bracket_nesting_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bracket nesting checker
// Checks bracket nesting per line and reports one result at each line end.
// ----------------------------------------------------------------------------
// The block takes one character beat per cycle; the beat with tlast set ends
// a line and produces one result beat on the master side (tuser holds the
// line status). The open brackets live in a chain of STACK_DEPTH cells that
// shift down on push and up on pop, so the top of stack is always cell 0.
// A line end passes through S_WAIT, which hands the result to the output
// register, and first through S_FOLD when the line is incomplete, because
// the completion score pops the chain one entry per cycle through a single
// multiply-by-five accumulator. S_WAIT holds while the previous result is
// still waiting at the output. Input is held off in both states; a result
// waiting at the output does not stall ordinary characters.
// ----------------------------------------------------------------------------
module bracket_nesting_checker import bnc_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] char_code
  input  logic        s_axis_tlast,  // line_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,  // [7:0] offending_char, [22:8] error_score,
                                     // [86:23] completion_score, [87] zero
  output logic [1:0]  m_axis_tuser   // [1:0] line_status
);

  localparam int unsigned DW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    S_RUN  = 3'b001,
    S_FOLD = 3'b010,
    S_WAIT = 3'b100
  } state_e;

  state_e state_d, state_q;

  logic [DW-1:0]     depth_d, depth_q;
  logic              corr_d, corr_q;
  logic              ovf_d, ovf_q;
  logic [CHAR_W-1:0] bad_d, bad_q;

  line_status_e      res_status_d, res_status_q;
  logic [CHAR_W-1:0] res_bad_d, res_bad_q;
  logic [ERR_W-1:0]  res_err_d, res_err_q;

  logic               out_v_q;
  line_status_e       out_status_q;
  logic [CHAR_W-1:0]  out_bad_q;
  logic [ERR_W-1:0]   out_err_q;
  logic [SCORE_W-1:0] out_comp_q;

  logic               in_acc;
  logic               out_free;
  kind_t              op_k, cl_k;
  logic               ignore, full, match;
  logic               do_push, do_pop, ovf_set, corr_set;
  logic               corr_n, ovf_n;
  logic [CHAR_W-1:0]  bad_n;
  logic [DW-1:0]      depth_n;
  line_status_e       status_n;
  shift_t             shift;
  logic               fold_clr, fold_step;
  logic [SCORE_W-1:0] acc;

  logic [KIND_W-1:0] cell_kind [STACK_DEPTH];

  assign s_axis_tready = (state_q == S_RUN);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_v_q || m_axis_tready;

  // Character decode against the current top of stack
  always_comb begin
    op_k     = opener_kind(s_axis_tdata);
    cl_k     = closer_kind(s_axis_tdata);
    ignore   = corr_q || ovf_q;
    full     = (depth_q == DW'(STACK_DEPTH));
    match    = (depth_q != '0) && (cell_kind[0] == cl_k.kind);
    do_push  = !ignore && op_k.hit && !full;
    ovf_set  = !ignore && op_k.hit && full;
    do_pop   = !ignore && cl_k.hit && match;
    corr_set = !ignore && cl_k.hit && !match;
    corr_n   = corr_q || corr_set;
    ovf_n    = ovf_q || ovf_set;
    bad_n    = corr_set ? s_axis_tdata : bad_q;
    depth_n  = depth_q + {{(DW-1){1'b0}}, do_push} - {{(DW-1){1'b0}}, do_pop};
    if (ovf_n) begin
      status_n = LS_OVERFLOW;
    end else if (corr_n) begin
      status_n = LS_CORRUPTED;
    end else if (depth_n != '0) begin
      status_n = LS_INCOMPLETE;
    end else begin
      status_n = LS_BALANCED;
    end
  end

  always_comb begin
    state_d      = state_q;
    depth_d      = depth_q;
    corr_d       = corr_q;
    ovf_d        = ovf_q;
    bad_d        = bad_q;
    res_status_d = res_status_q;
    res_bad_d    = res_bad_q;
    res_err_d    = res_err_q;
    shift        = '0;
    fold_clr     = 1'b0;
    fold_step    = 1'b0;
    case (state_q)
      S_RUN: begin
        if (in_acc) begin
          shift.push = do_push;
          shift.pop  = do_pop;
          depth_d    = depth_n;
          corr_d     = corr_n;
          ovf_d      = ovf_n;
          bad_d      = bad_n;
          if (s_axis_tlast) begin
            // Latch the line result, then clear the line state
            res_status_d = status_n;
            res_bad_d    = (status_n == LS_CORRUPTED) ? bad_n : '0;
            res_err_d    = (status_n == LS_CORRUPTED) ? error_points(bad_n) : '0;
            fold_clr     = 1'b1;
            corr_d       = 1'b0;
            ovf_d        = 1'b0;
            bad_d        = '0;
            if (status_n == LS_INCOMPLETE) begin
              state_d = S_FOLD;
            end else begin
              depth_d = '0;
              state_d = S_WAIT;
            end
          end
        end
      end
      S_FOLD: begin
        // Pop the top cell into the score each cycle
        shift.pop = 1'b1;
        fold_step = 1'b1;
        depth_d   = depth_q - {{(DW-1){1'b0}}, 1'b1};
        if (depth_q == {{(DW-1){1'b0}}, 1'b1}) begin
          state_d = S_WAIT;
        end
      end
      S_WAIT: begin
        if (out_free) begin
          state_d = S_RUN;
        end
      end
      default: state_d = S_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_RUN;
      depth_q <= '0;
      corr_q  <= 1'b0;
      ovf_q   <= 1'b0;
      bad_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      depth_q <= depth_d;
      corr_q  <= corr_d;
      ovf_q   <= ovf_d;
      bad_q   <= bad_d;
      if (state_q == S_WAIT && out_free) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_status_q <= res_status_d;
    res_bad_q    <= res_bad_d;
    res_err_q    <= res_err_d;
    if (state_q == S_WAIT && out_free) begin
      out_status_q <= res_status_q;
      out_bad_q    <= res_bad_q;
      out_err_q    <= res_err_q;
      out_comp_q   <= acc;
    end
  end

  // Stack chain: cell 0 is the top of stack
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [KIND_W-1:0] above, below;
    if (i == 0) begin : g_top
      assign above = op_k.kind;
    end else begin : g_mid
      assign above = cell_kind[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bot
      assign below = '0;
    end else begin : g_inner
      assign below = cell_kind[i+1];
    end
    bnc_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (shift),
      .above_i (above),
      .below_i (below),
      .kind_o  (cell_kind[i])
    );
  end

  bnc_fold u_fold (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .clr_i  (fold_clr),
    .step_i (fold_step),
    .kind_i (cell_kind[0]),
    .acc_o  (acc)
  );

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {1'b0, out_comp_q, out_err_q, out_bad_q};

  // Stack never claims more entries than cells
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DW'(STACK_DEPTH))
    else $error("stack depth beyond cell count");

  // The fold always has an entry to pop
  a_fold_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FOLD) |-> (depth_q != '0))
    else $error("fold with empty stack");

  // A line end clears the per-line flags
  a_line_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tlast) |=> (!corr_q && !ovf_q && bad_q == '0))
    else $error("line state not cleared at line end");

  // A result leaves the wait state only into a loaded output register
  a_wait_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WAIT && state_d == S_RUN) |=> m_axis_tvalid)
    else $error("result dropped on hand-off");

endmodule

/* tb/sv/bracket_nesting_checker_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bracket nesting checker testbench
// Streams text lines into the checker one character beat at a time and
// tracks the expected line result as each beat is accepted. Every result
// beat is compared field by field with the oldest expected result. Directed
// lines cover each mismatch, closers on an empty stack, ignored bytes and the
// stack limit. Random lines follow, with random idling on both sides.
// ----------------------------------------------------------------------------
module bracket_nesting_checker_tb;
  import bnc_pkg::*;

  localparam int unsigned STACK_LIMIT  = STACK_DEPTH_DEF;
  localparam int unsigned RANDOM_CHARS = 1000;
  localparam int unsigned MAX_REPORTS  = 10;

  localparam logic [CHAR_W-1:0] CH_LPAREN  = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN  = 8'h29;
  localparam logic [CHAR_W-1:0] CH_LSQUARE = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_RSQUARE = 8'h5D;
  localparam logic [CHAR_W-1:0] CH_LCURLY  = 8'h7B;
  localparam logic [CHAR_W-1:0] CH_RCURLY  = 8'h7D;
  localparam logic [CHAR_W-1:0] CH_LANGLE  = 8'h3C;
  localparam logic [CHAR_W-1:0] CH_RANGLE  = 8'h3E;

  localparam logic [ERR_W-1:0] PTS_PAREN  = 15'd3;
  localparam logic [ERR_W-1:0] PTS_SQUARE = 15'd57;
  localparam logic [ERR_W-1:0] PTS_CURLY  = 15'd1197;
  localparam logic [ERR_W-1:0] PTS_ANGLE  = 15'd25137;

  typedef enum logic [1:0] {
    KIND_PAREN,
    KIND_SQUARE,
    KIND_CURLY,
    KIND_ANGLE
  } bracket_kind_e;

  typedef struct packed {
    line_status_e       status;
    logic [CHAR_W-1:0]  offending;
    logic [ERR_W-1:0]   points;
    logic [SCORE_W-1:0] completion;
  } line_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [87:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  // Line state as the checker should hold it
  bracket_kind_e     open_kinds [STACK_LIMIT];
  int unsigned       open_count;
  bit                line_bad;
  bit                line_over;
  logic [CHAR_W-1:0] first_bad;

  line_result_t expected_lines [$];
  int unsigned  mismatch_count;
  int unsigned  chars_sent;
  bit           steady_sender;

  bracket_nesting_checker #(
    .STACK_DEPTH(STACK_LIMIT)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic bit opener_of(input logic [CHAR_W-1:0] c, output bracket_kind_e k);
    bit hit;
    hit = 1'b1;
    k   = KIND_PAREN;
    case (c)
      CH_LPAREN:  k = KIND_PAREN;
      CH_LSQUARE: k = KIND_SQUARE;
      CH_LCURLY:  k = KIND_CURLY;
      CH_LANGLE:  k = KIND_ANGLE;
      default:    hit = 1'b0;
    endcase
    return hit;
  endfunction

  function automatic bit closer_of(input logic [CHAR_W-1:0] c, output bracket_kind_e k);
    bit hit;
    hit = 1'b1;
    k   = KIND_PAREN;
    case (c)
      CH_RPAREN:  k = KIND_PAREN;
      CH_RSQUARE: k = KIND_SQUARE;
      CH_RCURLY:  k = KIND_CURLY;
      CH_RANGLE:  k = KIND_ANGLE;
      default:    hit = 1'b0;
    endcase
    return hit;
  endfunction

  function automatic logic [ERR_W-1:0] points_of(input logic [CHAR_W-1:0] c);
    logic [ERR_W-1:0] p;
    case (c)
      CH_RPAREN:  p = PTS_PAREN;
      CH_RSQUARE: p = PTS_SQUARE;
      CH_RCURLY:  p = PTS_CURLY;
      CH_RANGLE:  p = PTS_ANGLE;
      default:    p = '0;
    endcase
    return p;
  endfunction

  function automatic logic [CHAR_W-1:0] opener_char(input bracket_kind_e k);
    logic [CHAR_W-1:0] c;
    case (k)
      KIND_PAREN:  c = CH_LPAREN;
      KIND_SQUARE: c = CH_LSQUARE;
      KIND_CURLY:  c = CH_LCURLY;
      default:     c = CH_LANGLE;
    endcase
    return c;
  endfunction

  function automatic logic [CHAR_W-1:0] closer_char(input bracket_kind_e k);
    logic [CHAR_W-1:0] c;
    case (k)
      KIND_PAREN:  c = CH_RPAREN;
      KIND_SQUARE: c = CH_RSQUARE;
      KIND_CURLY:  c = CH_RCURLY;
      default:     c = CH_RANGLE;
    endcase
    return c;
  endfunction

  // Advance the line state by one accepted character; queue a result at line end
  function automatic void track_char(input logic [CHAR_W-1:0] c, input bit last);
    bracket_kind_e k;
    line_result_t  r;
    int            idx;
    if (!line_bad && !line_over) begin
      if (opener_of(c, k)) begin
        if (open_count >= STACK_LIMIT) begin
          line_over = 1'b1;
        end else begin
          open_kinds[open_count] = k;
          open_count++;
        end
      end else if (closer_of(c, k)) begin
        if (open_count > 0 && open_kinds[open_count-1] == k) begin
          open_count--;
        end else begin
          line_bad  = 1'b1;
          first_bad = c;
        end
      end
    end
    if (last) begin
      r        = '0;
      r.status = LS_BALANCED;
      if (line_over) begin
        r.status = LS_OVERFLOW;
      end else if (line_bad) begin
        r.status    = LS_CORRUPTED;
        r.offending = first_bad;
        r.points    = points_of(first_bad);
      end else if (open_count > 0) begin
        r.status = LS_INCOMPLETE;
        // fold from the top of the stack down, wrapping at 64 bits
        idx = int'(open_count) - 1;
        while (idx >= 0) begin
          r.completion = r.completion * 64'd5 + 64'(open_kinds[idx]) + 64'd1;
          idx--;
        end
      end
      expected_lines.insert(expected_lines.size(), r);
      open_count = 0;
      line_bad   = 1'b0;
      line_over  = 1'b0;
      first_bad  = '0;
    end
  endfunction

  function automatic void check_line_result();
    line_result_t want;
    line_result_t got;
    got.status     = line_status_e'(m_axis_tuser);
    got.offending  = m_axis_tdata[7:0];
    got.points     = m_axis_tdata[22:8];
    got.completion = m_axis_tdata[86:23];
    if (expected_lines.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display({"%0t: result beat with no line pending:",
                  " status %0d offend %h points %0d score %h"},
                 $time, got.status, got.offending, got.points, got.completion);
    end else begin
      want = expected_lines.pop_front();
      if (want !== got || m_axis_tdata[87] !== 1'b0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display({"%0t: line result mismatch: expected status %0d offend %h points %0d",
                    " score %h, got status %0d offend %h points %0d score %h pad %b"},
                   $time, want.status, want.offending, want.points, want.completion,
                   got.status, got.offending, got.points, got.completion, m_axis_tdata[87]);
      end
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_line_result();
  end

  // Receiver: ready stretches and stalls, mostly short, a few long
  initial begin
    int unsigned hold;
    int unsigned roll;
    m_axis_tready = 1'b0;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (hold != 0) begin
        hold--;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
          m_axis_tready = 1'b1;
          hold = $urandom_range(40, 200);
        end else if (roll < 55) begin
          m_axis_tready = 1'b1;
          hold = $urandom_range(0, 8);
        end else if (roll < 88) begin
          m_axis_tready = 1'b0;
          hold = $urandom_range(0, 2);
        end else if (roll < 96) begin
          m_axis_tready = 1'b0;
          hold = $urandom_range(3, 12);
        end else begin
          m_axis_tready = 1'b0;
          hold = $urandom_range(20, 60);
        end
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 0;
    if (roll < 94) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken
  task automatic send_char(input logic [CHAR_W-1:0] c, input bit last);
    int unsigned gap;
    gap = steady_sender ? 0 : pick_gap();
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = c;
    s_axis_tlast  = last;
    do @(posedge clk_i); while (!s_axis_tready);
    track_char(c, last);
    chars_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_line(input logic [CHAR_W-1:0] text [$]);
    int unsigned idx;
    for (idx = 0; idx < text.size(); idx++) send_char(text[idx], idx == text.size() - 1);
  endtask

  task automatic send_text(input string s);
    int unsigned idx;
    for (idx = 0; idx < s.len(); idx++) send_char(s[idx], idx == s.len() - 1);
  endtask

  // Hold the sender until every pending line result has come back
  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (expected_lines.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic test_bracket_pairs();
    send_text("()");
    send_text("[<{(a)}>]");
    send_text("(]");
    send_text("[)");
    send_text("{>");
    send_text("<}");
    send_text("([{<");
    // after the first mismatch the rest of the line is dropped
    send_text("(]((()>");
    send_text("<");
  endtask

  task automatic test_empty_stack_closers();
    send_text(")");
    send_text("]");
    send_text("}");
    send_text(">");
    send_text("()>");
  endtask

  task automatic test_ignored_bytes();
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(8'h0A, 1'b0);
    send_char(8'h80, 1'b0);
    send_char(8'h7F, 1'b1);
    send_text("(x");
    send_text("z");
  endtask

  task automatic test_stack_limit();
    logic [CHAR_W-1:0] text [$];
    bracket_kind_e     kinds [$];
    bracket_kind_e     k;
    // fill to the limit exactly: deepest incomplete line, score wraps
    repeat (STACK_LIMIT) begin
      k = bracket_kind_e'($urandom_range(0, 3));
      kinds.insert(kinds.size(), k);
      text.insert(text.size(), opener_char(k));
    end
    steady_sender = 1'b1;
    send_line(text);
    steady_sender = 1'b0;
    // same fill, then unwind all of it
    while (kinds.size() != 0) begin
      text.insert(text.size(), closer_char(kinds[$]));
      kinds.delete(kinds.size() - 1);
    end
    send_line(text);
    // one opener past the limit; the closers after it are ignored
    text.delete();
    repeat (STACK_LIMIT + 1) text.insert(text.size(), CH_LCURLY);
    text.insert(text.size(), CH_RCURLY);
    text.insert(text.size(), CH_RPAREN);
    send_line(text);
    // overflow on the line end itself
    text.delete();
    repeat (STACK_LIMIT + 1) text.insert(text.size(), CH_LANGLE);
    send_line(text);
    // corrupted first: the long run of openers after it must not overflow
    text.delete();
    text.insert(text.size(), CH_RSQUARE);
    repeat (STACK_LIMIT + 2) text.insert(text.size(), CH_LPAREN);
    send_line(text);
  endtask

  task automatic test_random_lines();
    logic [CHAR_W-1:0] text [$];
    bracket_kind_e     open_q [$];
    bracket_kind_e     k;
    int unsigned       shape;
    int unsigned       roll;
    int unsigned       len;
    int unsigned       depth_cap;
    int unsigned       bad_at;
    int unsigned       idx;
    bit                halfway_done;
    chars_sent   = 0;
    halfway_done = 1'b0;
    while (chars_sent < RANDOM_CHARS) begin
      text.delete();
      open_q.delete();
      steady_sender = ($urandom_range(0, 3) == 0);
      shape = $urandom_range(0, 99);
      if (shape < 2) begin
        repeat (STACK_LIMIT + $urandom_range(1, 3))
          text.insert(text.size(), opener_char(bracket_kind_e'($urandom_range(0, 3))));
        repeat ($urandom_range(0, 4)) text.insert(text.size(), 8'($urandom_range(0, 255)));
      end else if (shape < 6) begin
        repeat ($urandom_range(1, 12)) text.insert(text.size(), 8'($urandom_range(0, 255)));
      end else begin
        roll      = $urandom_range(0, 19);
        depth_cap = (roll == 0) ? STACK_LIMIT : (roll < 4) ? 32 : 6;
        len       = $urandom_range(1, (roll == 0) ? 2 * STACK_LIMIT : 20);
        bad_at    = (shape < 26) ? $urandom_range(0, len - 1) : len;
        for (idx = 0; idx < len; idx++) begin
          if (idx == bad_at) begin
            // a closer that misses the top, or any closer on an empty stack
            k = bracket_kind_e'($urandom_range(0, 3));
            if (open_q.size() != 0 && k == open_q[$]) k = bracket_kind_e'(2'(k + 1));
            text.insert(text.size(), closer_char(k));
          end else begin
            roll = $urandom_range(0, 9);
            if (roll < 4 && open_q.size() < depth_cap) begin
              k = bracket_kind_e'($urandom_range(0, 3));
              open_q.insert(open_q.size(), k);
              text.insert(text.size(), opener_char(k));
            end else if (roll < 8 && open_q.size() != 0) begin
              text.insert(text.size(), closer_char(open_q[$]));
              open_q.delete(open_q.size() - 1);
            end else begin
              text.insert(text.size(), 8'($urandom_range(0, 255)));
            end
          end
        end
        // close out the balanced shapes, leave the rest open
        if (shape >= 60) begin
          while (open_q.size() != 0) begin
            text.insert(text.size(), closer_char(open_q[$]));
            open_q.delete(open_q.size() - 1);
          end
        end
      end
      send_line(text);
      if (!halfway_done && chars_sent >= RANDOM_CHARS / 2) begin
        wait_drained();
        halfway_done = 1'b1;
      end
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tlast   = 1'b0;
    open_count     = 0;
    line_bad       = 1'b0;
    line_over      = 1'b0;
    first_bad      = '0;
    mismatch_count = 0;
    chars_sent     = 0;
    steady_sender  = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_bracket_pairs();
    test_empty_stack_closers();
    test_ignored_bytes();
    wait_drained();
    test_stack_limit();
    test_random_lines();

    wait_drained();
    repeat (STACK_LIMIT + 16) @(posedge clk_i);
    if (mismatch_count == 0 && expected_lines.size() == 0) begin
      $display("bracket_nesting_checker regression: pass");
    end else begin
      $display("bracket_nesting_checker regression: fail");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("bracket_nesting_checker regression: fail");
    $finish;
  end

endmodule
